/* rtl/crb_pkg.sv */
`timescale 1ns / 1ps

package crb_pkg;

    localparam int CRB_DEPTH     = 1024;
    localparam int CRB_MAX_CHUNK = 64;
    localparam int LEN_W         = 7;
    localparam int DATA_W        = 8;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CK_FREE,
        S_CK_SPACE,
        S_CK_FIT,
        S_CK_ORDER,
        S_CK_RIGHT,
        S_CK_WRAP,
        S_CK_HEAD,
        S_WR,
        S_EMIT,
        S_RD_LIM,
        S_RD_ADDR,
        S_RD_DATA
    } state_t;

endpackage

/* rtl/crb_ram.sv */
`timescale 1ns / 1ps

module crb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/crb_alu.sv */
`timescale 1ns / 1ps

// Shared subtractor: difference plus borrow (a < b).
module crb_alu #(
    parameter int W = 11
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

/* rtl/chunk_ring_buffer_top.sv */
`timescale 1ns / 1ps

// Flow: a write byte passes S_WR and S_EMIT, after the S_CK_* checks at a chunk start;
// clear and short reads pass S_EMIT; a read passes S_RD_LIM, then S_RD_ADDR and
// S_RD_DATA per byte. Throughput: one input word at a time; in_stall is high until
// its last result is loaded. Chunk checks and index settling share one subtractor.
// Reset: rst_n asynchronous, active low; clears indices, counts, chunk state and
// padding_mode. Buffer memory is not cleared and needs no clearing pass.
module chunk_ring_buffer_top
    import crb_pkg::*;
#(
    parameter int DEPTH     = CRB_DEPTH,
    parameter int MAX_CHUNK = CRB_MAX_CHUNK
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic              chunk_start,
    input  logic [LEN_W-1:0]  chunk_len,
    input  logic [DATA_W-1:0] data_in,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [DATA_W-1:0] data_out,
    output logic              last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ALU_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // Sequencer and buffer bookkeeping
    state_t                   state_reg,      state_next;
    logic [IDX_W-1:0]         rd_idx_reg,     rd_idx_next;
    logic [IDX_W-1:0]         wr_idx_reg,     wr_idx_next;
    logic [CNT_W-1:0]         used_reg,       used_next;
    logic [CNT_W-1:0]         pad_reg,        pad_next;
    logic [LEN_W-1:0]         chunk_left_reg, chunk_left_next;
    logic                     chunk_ok_reg,   chunk_ok_next;
    logic                     pad_mode_reg,   pad_mode_next;
    logic                     out_valid_reg,  out_valid_next;

    // Working registers of the current word
    logic [IDX_W-1:0]         pad_lim_reg,    pad_lim_next;
    logic [ALU_W-1:0]         tmp_reg,        tmp_next;
    logic                     eq_reg,         eq_next;
    logic                     ok_reg,         ok_next;
    logic [LEN_W-1:0]         len_reg,        len_next;
    logic [DATA_W-1:0]        data_reg,       data_next;
    logic [LEN_W-1:0]         cnt_reg,        cnt_next;
    status_t                  res_status_reg, res_status_next;
    status_t                  out_status_reg, out_status_next;
    logic [DATA_W-1:0]        out_data_reg,   out_data_next;
    logic                     out_last_reg,   out_last_next;

    logic [ALU_W-1:0]         alu_a;
    logic [ALU_W-1:0]         alu_b;
    logic [ALU_W-1:0]         alu_diff;
    logic                     alu_borrow;

    logic                     ram_we;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     slot_free;
    logic [IDX_W-1:0]         rd_inc;
    logic [IDX_W-1:0]         wr_inc;
    logic                     len_bad;
    func_t                    in_func;

    assign in_func   = func_t'(func);
    assign slot_free = !out_valid_reg || !out_stall;
    assign rd_inc    = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign wr_inc    = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    // A chunk of length zero or above the chunk limit is refused before any check.
    assign len_bad   = (chunk_len == '0) || (chunk_len > LEN_W'(MAX_CHUNK));

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = out_data_reg;
    assign last      = out_last_reg;

    crb_alu #(
        .W (ALU_W)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    crb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (data_reg),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_func)
                        FUNC_WRITE:
                        begin
                            if (chunk_start && !len_bad)
                            begin
                                state_next = S_CK_FREE;
                            end
                            else
                            begin
                                state_next = S_WR;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (used_reg == '0 || chunk_len == '0)
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_RD_LIM;
                            end
                        end
                        FUNC_CLEAR: state_next = S_EMIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_CK_FREE:  state_next = S_CK_SPACE;
            S_CK_SPACE: state_next = S_CK_FIT;
            S_CK_FIT:
            begin
                if (alu_borrow || pad_reg != '0)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_CK_ORDER;
                end
            end
            S_CK_ORDER:
            begin
                if (alu_borrow)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_CK_RIGHT;
                end
            end
            S_CK_RIGHT: state_next = S_CK_WRAP;
            S_CK_WRAP:
            begin
                if (!alu_borrow || !pad_mode_reg)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_CK_HEAD;
                end
            end
            S_CK_HEAD:  state_next = S_WR;
            S_WR:       state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RD_LIM:   state_next = S_RD_ADDR;
            S_RD_ADDR:
            begin
                if (slot_free)
                begin
                    state_next = S_RD_DATA;
                end
            end
            S_RD_DATA:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD_ADDR;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath control and register updates
    always_comb
    begin
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        used_next       = used_reg;
        pad_next        = pad_reg;
        chunk_left_next = chunk_left_reg;
        chunk_ok_next   = chunk_ok_reg;
        pad_mode_next   = cfg_wr_en ? cfg_wr_data : pad_mode_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pad_lim_next    = pad_lim_reg;
        tmp_next        = tmp_reg;
        eq_next         = eq_reg;
        ok_next         = ok_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        alu_a           = '0;
        alu_b           = '0;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    len_next  = chunk_len;
                    data_next = data_in;
                    case (in_func)
                        FUNC_WRITE:
                        begin
                            ok_next = 1'b0;
                            if (chunk_start)
                            begin
                                // A new chunk abandons any unfinished one.
                                chunk_left_next = (chunk_len == '0) ? '0 : chunk_len - 1'b1;
                                chunk_ok_next   = 1'b0;
                            end
                            else if (chunk_left_reg != '0)
                            begin
                                chunk_left_next = chunk_left_reg - 1'b1;
                                ok_next         = chunk_ok_reg;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (used_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                res_status_next = STATUS_OK;
                            end
                            cnt_next = (chunk_len > LEN_W'(MAX_CHUNK)) ?
                                       LEN_W'(MAX_CHUNK) : chunk_len;
                        end
                        FUNC_CLEAR:
                        begin
                            rd_idx_next     = '0;
                            wr_idx_next     = '0;
                            used_next       = '0;
                            pad_next        = '0;
                            chunk_left_next = '0;
                            chunk_ok_next   = 1'b0;
                            res_status_next = STATUS_OK;
                        end
                        default:
                        begin
                            res_status_next = res_status_reg;
                        end
                    endcase
                end
            end
            // free = DEPTH - used - pad, in two passes
            S_CK_FREE:
            begin
                alu_a    = ALU_W'(DEPTH);
                alu_b    = ALU_W'(used_reg);
                tmp_next = alu_diff;
            end
            S_CK_SPACE:
            begin
                alu_a    = tmp_reg;
                alu_b    = ALU_W'(pad_reg);
                tmp_next = alu_diff;
            end
            S_CK_FIT:
            begin
                alu_a = tmp_reg;
                alu_b = ALU_W'(len_reg);
                // With padding pending the chunk goes straight behind the data.
                if (!alu_borrow && pad_reg != '0)
                begin
                    ok_next       = 1'b1;
                    chunk_ok_next = 1'b1;
                end
            end
            S_CK_ORDER:
            begin
                alu_a   = ALU_W'(wr_idx_reg);
                alu_b   = ALU_W'(rd_idx_reg);
                eq_next = (alu_diff == '0);
                if (alu_borrow)
                begin
                    ok_next       = 1'b1;
                    chunk_ok_next = 1'b1;
                end
            end
            S_CK_RIGHT:
            begin
                alu_a    = ALU_W'(DEPTH);
                alu_b    = ALU_W'(wr_idx_reg);
                tmp_next = alu_diff;
            end
            S_CK_WRAP:
            begin
                alu_a = tmp_reg;
                alu_b = ALU_W'(len_reg);
                if (!alu_borrow || !pad_mode_reg)
                begin
                    ok_next       = 1'b1;
                    chunk_ok_next = 1'b1;
                end
            end
            S_CK_HEAD:
            begin
                // Chunk must fit ahead of the read index at the start.
                alu_a = ALU_W'(rd_idx_reg);
                alu_b = ALU_W'(len_reg);
                if (!alu_borrow)
                begin
                    ok_next       = 1'b1;
                    chunk_ok_next = 1'b1;
                    pad_lim_next  = wr_idx_reg;
                    wr_idx_next   = '0;
                    if (eq_reg)
                    begin
                        // Empty buffer: the read index jumps over the gap at once.
                        rd_idx_next = '0;
                        pad_next    = '0;
                    end
                    else
                    begin
                        pad_next = CNT_W'(tmp_reg);
                    end
                end
            end
            S_WR:
            begin
                if (ok_reg)
                begin
                    ram_we      = 1'b1;
                    wr_idx_next = wr_inc;
                    used_next   = used_reg + 1'b1;
                end
                if (chunk_left_reg == '0)
                begin
                    chunk_ok_next = 1'b0;
                end
                res_status_next = ok_reg ? STATUS_OK : STATUS_REJECT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
            S_RD_LIM:
            begin
                // Cap the byte count at what is stored.
                alu_a = ALU_W'(used_reg);
                alu_b = ALU_W'(cnt_reg);
                if (alu_borrow)
                begin
                    cnt_next = LEN_W'(used_reg);
                end
            end
            S_RD_ADDR:
            begin
                alu_a = ALU_W'(rd_inc);
                alu_b = ALU_W'(pad_lim_reg);
                if (slot_free)
                begin
                    // Skip the padding gap once the read index reaches it.
                    if (pad_reg != '0 && !alu_borrow)
                    begin
                        rd_idx_next = '0;
                        pad_next    = '0;
                    end
                    else
                    begin
                        rd_idx_next = rd_inc;
                    end
                    used_next = used_reg - 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            S_RD_DATA:
            begin
                out_valid_next  = 1'b1;
                out_status_next = STATUS_OK;
                out_data_next   = ram_rdata;
                out_last_next   = (cnt_reg == '0);
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            used_reg       <= '0;
            pad_reg        <= '0;
            chunk_left_reg <= '0;
            chunk_ok_reg   <= 1'b0;
            pad_mode_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            used_reg       <= used_next;
            pad_reg        <= pad_next;
            chunk_left_reg <= chunk_left_next;
            chunk_ok_reg   <= chunk_ok_next;
            pad_mode_reg   <= pad_mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pad_lim_reg    <= pad_lim_next;
        tmp_reg        <= tmp_next;
        eq_reg         <= eq_next;
        ok_reg         <= ok_next;
        len_reg        <= len_next;
        data_reg       <= data_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    // Stored bytes plus padding never exceed the buffer.
    a_space_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(used_reg) + (CNT_W + 1)'(pad_reg)) <= (CNT_W + 1)'(DEPTH))
        else $error("used plus padding exceeds depth");

    // Padding gap always ends exactly at the buffer end.
    a_pad_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (pad_reg != '0) |->
        ((CNT_W + 1)'(pad_lim_reg) + (CNT_W + 1)'(pad_reg)) == (CNT_W + 1)'(DEPTH))
        else $error("padding limit out of step with padding count");

    // Never fetch a byte with nothing left to read.
    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_ADDR) |-> (cnt_reg != '0))
        else $error("read fetch with zero count");

    // A fetched byte always lands in the output word.
    a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_DATA) |=> out_valid_reg)
        else $error("read byte not loaded");

endmodule

/* bench/chunk_ring_buffer_top_tb.sv */
`timescale 1ns / 1ps

module chunk_ring_buffer_top_tb;
    import crb_pkg::*;

    // How a stimulus word is checked: against the predictor, against no
    // result at all, or against one status word typed into the table.
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ONE
    } chk_t;

    typedef struct packed {
        func_t             fn;
        logic              first;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        chk_t              chk;
        status_t           want;
    } plan_row_t;

    typedef struct packed {
        status_t           st;
        logic [DATA_W-1:0] data;
        logic              last;
    } ring_word_t;

    // Directed words, run with padding off right after reset.
    localparam int PLAN_LEN = 24;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{FUNC_READ,  1'b0, 7'd5,   8'h00, CHK_ONE,     STATUS_EMPTY},
        '{FUNC_WRITE, 1'b0, 7'd3,   8'h00, CHK_ONE,     STATUS_REJECT},
        '{FUNC_NONE,  1'b0, 7'd0,   8'h00, CHK_NONE,    STATUS_OK},
        '{FUNC_WRITE, 1'b1, 7'd0,   8'h11, CHK_ONE,     STATUS_REJECT},
        '{FUNC_WRITE, 1'b1, 7'd65,  8'h22, CHK_ONE,     STATUS_REJECT},
        '{FUNC_WRITE, 1'b0, 7'd0,   8'h33, CHK_ONE,     STATUS_REJECT},
        '{FUNC_WRITE, 1'b1, 7'd127, 8'h44, CHK_ONE,     STATUS_REJECT},
        '{FUNC_WRITE, 1'b1, 7'd1,   8'hFF, CHK_ONE,     STATUS_OK},
        '{FUNC_WRITE, 1'b0, 7'd0,   8'h55, CHK_ONE,     STATUS_REJECT},
        '{FUNC_WRITE, 1'b1, 7'd4,   8'h00, CHK_PREDICT, STATUS_OK},
        '{FUNC_WRITE, 1'b0, 7'd0,   8'hA5, CHK_PREDICT, STATUS_OK},
        '{FUNC_WRITE, 1'b0, 7'd0,   8'h5A, CHK_PREDICT, STATUS_OK},
        '{FUNC_WRITE, 1'b1, 7'd64,  8'hC3, CHK_PREDICT, STATUS_OK},
        '{FUNC_WRITE, 1'b1, 7'd2,   8'h7F, CHK_PREDICT, STATUS_OK},
        '{FUNC_WRITE, 1'b0, 7'd0,   8'h80, CHK_PREDICT, STATUS_OK},
        '{FUNC_READ,  1'b0, 7'd0,   8'h00, CHK_ONE,     STATUS_OK},
        '{FUNC_READ,  1'b0, 7'd2,   8'h00, CHK_PREDICT, STATUS_OK},
        '{FUNC_READ,  1'b1, 7'd127, 8'h00, CHK_PREDICT, STATUS_OK},
        '{FUNC_READ,  1'b0, 7'd64,  8'h00, CHK_ONE,     STATUS_EMPTY},
        '{FUNC_WRITE, 1'b1, 7'd3,   8'h01, CHK_PREDICT, STATUS_OK},
        '{FUNC_CLEAR, 1'b0, 7'd0,   8'h00, CHK_ONE,     STATUS_OK},
        '{FUNC_WRITE, 1'b0, 7'd0,   8'h02, CHK_ONE,     STATUS_REJECT},
        '{FUNC_READ,  1'b0, 7'd1,   8'h00, CHK_ONE,     STATUS_EMPTY},
        '{FUNC_NONE,  1'b1, 7'd127, 8'hFF, CHK_NONE,    STATUS_OK}
    };

    // Padding setting of each random phase, in order.
    localparam bit PHASE_PAD [3] = '{1'b1, 1'b0, 1'b1};
    localparam int PHASE_CAP     = 45;
    localparam int SETTLE_CYCLES = 16;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic              cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        func;
    logic              chunk_start;
    logic [LEN_W-1:0]  chunk_len;
    logic [DATA_W-1:0] data_in;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
    logic              last;

    // Predicted ring state, kept in step with every accepted input word.
    bit                pad_on;
    logic [10:0]       rd_ptr;
    logic [10:0]       wr_ptr;
    logic [10:0]       fill;
    logic [10:0]       pad_gap;
    logic [LEN_W-1:0]  chunk_rem;
    bit                chunk_good;
    logic [DATA_W-1:0] ring_mem [CRB_DEPTH];
    int                wraps;

    ring_word_t        fresh_words [$];
    ring_word_t        due_words [$];
    int                mismatch_count;
    int                phase_words;
    bit                quiet;

    chunk_ring_buffer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .chunk_start (chunk_start),
        .chunk_len   (chunk_len),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .data_out    (data_out),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // Mostly no pause, sometimes a short one, rarely a long one; none at all
    // while a quiet stretch is on.
    function automatic int pause_len();
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Jump the read pointer home once it reaches the padded tail gap.
    function automatic void skip_gap();
        if (rd_ptr >= CRB_DEPTH - pad_gap)
        begin
            rd_ptr  = '0;
            pad_gap = '0;
        end
    endfunction

    // Decide a whole chunk at its first word; may move the write pointer home.
    function automatic bit open_chunk(input logic [LEN_W-1:0] len);
        int room;
        int right;
        room       = CRB_DEPTH - fill - pad_gap;
        chunk_rem  = (len == 0) ? '0 : len - 1'b1;
        chunk_good = 1'b0;
        if (len == 0 || len > CRB_MAX_CHUNK || len > room)
            return 1'b0;
        if (pad_gap == 0 && wr_ptr >= rd_ptr)
        begin
            right = CRB_DEPTH - wr_ptr;
            if (right < len && pad_on)
            begin
                if (len > rd_ptr)
                    return 1'b0;
                pad_gap = 11'(right);
                wr_ptr  = '0;
                wraps++;
                skip_gap();
            end
        end
        chunk_good = 1'b1;
        return 1'b1;
    endfunction

    // Advance the predicted ring by one input word; push its result words
    // onto fresh_words.
    function automatic void ring_predict(input func_t fn, input logic first,
                                         input logic [LEN_W-1:0] len,
                                         input logic [DATA_W-1:0] d);
        bit ok;
        int n;
        int i;
        logic [DATA_W-1:0] b;
        case (fn)
            FUNC_WRITE:
            begin
                if (first)
                    ok = open_chunk(len);
                else if (chunk_rem > 0)
                begin
                    chunk_rem--;
                    ok = chunk_good;
                end
                else
                    ok = 1'b0;
                if (ok)
                begin
                    ring_mem[wr_ptr[9:0]] = d;
                    wr_ptr = wr_ptr + 1'b1;
                    if (wr_ptr >= CRB_DEPTH)
                    begin
                        wr_ptr = '0;
                        wraps++;
                    end
                    fill++;
                end
                if (chunk_rem == 0)
                    chunk_good = 1'b0;
                fresh_words.push_back('{ok ? STATUS_OK : STATUS_REJECT, 8'h00, 1'b1});
            end
            FUNC_READ:
            begin
                if (fill == 0)
                    fresh_words.push_back('{STATUS_EMPTY, 8'h00, 1'b1});
                else if (len == 0)
                    fresh_words.push_back('{STATUS_OK, 8'h00, 1'b1});
                else
                begin
                    n = len;
                    if (n > CRB_MAX_CHUNK)
                        n = CRB_MAX_CHUNK;
                    if (n > fill)
                        n = fill;
                    for (i = 0; i < n; i++)
                    begin
                        b = ring_mem[rd_ptr[9:0]];
                        rd_ptr = rd_ptr + 1'b1;
                        if (rd_ptr >= CRB_DEPTH)
                            rd_ptr = '0;
                        if (pad_gap != 0)
                            skip_gap();
                        fill--;
                        fresh_words.push_back('{STATUS_OK, b, i == n - 1});
                    end
                end
            end
            FUNC_CLEAR:
            begin
                rd_ptr     = '0;
                wr_ptr     = '0;
                fill       = '0;
                pad_gap    = '0;
                chunk_rem  = '0;
                chunk_good = 1'b0;
                fresh_words.push_back('{STATUS_OK, 8'h00, 1'b1});
            end
            default:
                ;
        endcase
    endfunction

    // Offer one word after a random pause, hold it until accepted, then
    // queue what it should produce.
    task automatic put_word(input func_t fn, input logic first,
                            input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] d,
                            input chk_t chk, input status_t want);
        int n;
        n = pause_len();
        repeat (n)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid    = 1'b1;
        func        = fn;
        chunk_start = first;
        chunk_len   = len;
        data_in     = d;
        do
            @(posedge clk);
        while (in_stall);
        phase_words++;
        fresh_words.delete();
        ring_predict(fn, first, len, d);
        case (chk)
            CHK_PREDICT:
                foreach (fresh_words[k])
                    due_words.push_back(fresh_words[k]);
            CHK_ONE:
                due_words.push_back('{want, 8'h00, 1'b1});
            default:
                ;
        endcase
    endtask

    // Drop valid and wait for every expected word, then let a word that
    // gives no result finish inside the block.
    task automatic drain_results();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (due_words.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stall the output side at random, with the same pause shape.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = pause_len();
            repeat (n)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        ring_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_words.size() == 0)
                flag($sformatf("unexpected word: status %0d data %h last %0d",
                               status, data_out, last));
            else
            begin
                want = due_words.pop_front();
                if (status !== want.st || data_out !== want.data || last !== want.last)
                    flag($sformatf("word mismatch: status %0d/%0d data %h/%h last %0d/%0d",
                                   want.st, status, want.data, data_out,
                                   want.last, last));
            end
        end
    end

    initial
    begin
        int p;
        int len;
        int sent;
        int k;
        int wraps_mark;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_NONE;
        chunk_start    = 1'b0;
        chunk_len      = '0;
        data_in        = '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        phase_words    = 0;
        wraps          = 0;
        pad_on         = 1'b0;
        rd_ptr         = '0;
        wr_ptr         = '0;
        fill           = '0;
        pad_gap        = '0;
        chunk_rem      = '0;
        chunk_good     = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: rejects, empty reads, the ignored code, clear.
        for (k = 0; k < PLAN_LEN; k++)
            put_word(PLAN[k].fn, PLAN[k].first, PLAN[k].len, PLAN[k].data,
                     PLAN[k].chk, PLAN[k].want);

        // Random phases. Each one runs for a fixed word budget, or until the
        // write pointer has gone around three times.
        foreach (PHASE_PAD[ph])
        begin
            drain_results();
            @(negedge clk);
            cfg_wr_en   = 1'b1;
            cfg_wr_data = PHASE_PAD[ph];
            @(posedge clk);
            pad_on = PHASE_PAD[ph];
            @(negedge clk);
            cfg_wr_en = 1'b0;

            phase_words = 0;
            wraps_mark  = wraps;
            while (wraps < wraps_mark + 3 && phase_words < PHASE_CAP)
            begin
                quiet = ($urandom_range(0, 9) == 0);
                p = $urandom_range(0, 99);
                if (p < 50)
                begin
                    // Chunk: mostly well formed, sometimes a bad length,
                    // cut short, or followed by a stray word.
                    k = $urandom_range(0, 99);
                    if (k < 8)
                        len = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                    else if (k < 25)
                        len = $urandom_range(1, 8);
                    else
                        len = $urandom_range(9, 64);
                    if (len == 0 || len > CRB_MAX_CHUNK)
                        sent = $urandom_range(1, 4);
                    else if ($urandom_range(0, 9) == 0)
                        sent = $urandom_range(1, len);
                    else
                        sent = len + ($urandom_range(0, 19) == 0);
                    // Cut the chunk at the end of the phase budget.
                    if (sent > PHASE_CAP - phase_words)
                        sent = PHASE_CAP - phase_words;
                    for (k = 0; k < sent; k++)
                        put_word(FUNC_WRITE, k == 0,
                                 LEN_W'((k == 0) ? len : $urandom_range(0, 127)),
                                 DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
                end
                else if (p < 78)
                begin
                    k = $urandom_range(0, 99);
                    if (k < 5)
                        len = 0;
                    else if (k < 12)
                        len = $urandom_range(65, 127);
                    else
                        len = $urandom_range(1, 64);
                    put_word(FUNC_READ, 1'($urandom_range(0, 1)), LEN_W'(len),
                             DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
                end
                else if (p < 84)
                begin
                    // Read the ring dry; padding may be met on the way.
                    while (fill != 0)
                        put_word(FUNC_READ, 1'($urandom_range(0, 1)), 7'd64,
                                 DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
                    put_word(FUNC_READ, 1'b0, LEN_W'($urandom_range(1, 127)),
                             DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
                end
                else if (p < 87)
                    put_word(FUNC_CLEAR, 1'($urandom_range(0, 1)),
                             LEN_W'($urandom_range(0, 127)),
                             DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
                else if (p < 90)
                    put_word(FUNC_NONE, 1'($urandom_range(0, 1)),
                             LEN_W'($urandom_range(0, 127)),
                             DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
                else
                    put_word(FUNC_WRITE, 1'b0, LEN_W'($urandom_range(0, 127)),
                             DATA_W'($urandom_range(0, 255)), CHK_PREDICT, STATUS_OK);
            end
        end

        quiet = 1'b0;
        drain_results();
        if (due_words.size() != 0)
            flag($sformatf("%0d expected words never arrived", due_words.size()));
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the handshake hangs.
    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/crb_pkg.sv
rtl/crb_ram.sv
rtl/crb_alu.sv
rtl/chunk_ring_buffer_top.sv
bench/chunk_ring_buffer_top_tb.sv
